// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the inward rectifier block.
// Each macro assumes clk_i and rst_ni exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock edge outside reset.
`define IRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("irc assertion failed");

// Implication checked in the same cycle.
`define IRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("irc assertion failed");

// Implication checked in the next cycle.
`define IRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("irc assertion failed");

`endif

// ===== rtl/irc_pkg.sv =====
// Shared types and fixed-point constants of the inward rectifier current block.
// No dependencies; imported by every module of the block.
package irc_pkg;

  localparam int LW = 28;   // log2 values, signed Q16
  localparam int DW = 18;   // driving force V - EK
  localparam int VW = 17;   // voltage fields
  localparam int GW = 18;   // conductance gain, Q16
  localparam int QW = 17;   // gate and 2^-t results, Q16

  typedef logic signed [LW-1:0] log_t;
  typedef logic        [LW-1:0] ulog_t;

  // Linear exponent terms: floor((d + C) * K / 256)
  localparam logic signed [19:0] C_ALPHA = -20'sd15159;
  localparam logic signed [19:0] C_B1    =  20'sd1402;
  localparam logic signed [19:0] C_B2    = -20'sd152143;
  localparam logic signed [19:0] C_DEN   =  20'sd1217;
  localparam logic signed [16:0] K_ALPHA =  17'sd22550;
  localparam logic signed [16:0] K_B1    =  17'sd7594;
  localparam logic signed [16:0] K_B2    =  17'sd5838;
  localparam logic signed [16:0] K_DEN   = -17'sd48626;

  localparam log_t LOG2_B1     = -28'sd67207;
  localparam log_t LOG2_ALPHA0 =  28'sd1872;

  // 2^-f polynomial and log2(1+u) polynomial
  localparam logic [15:0] P_LIN    = 16'd44013;
  localparam logic [13:0] P_SQR    = 14'd11245;
  localparam logic [32:0] L_LIN_SH = 33'd5755240448;  // 87818 * 2^16
  localparam logic [14:0] L_SQR    = 15'd22282;

  localparam logic [QW-1:0] Q_ONE   = 17'd65536;
  localparam logic [4:0]    SH_ZERO = 5'd17;          // shift code meaning result is zero

  localparam logic signed [16:0] I_MIN = -17'sd65536;
  localparam logic signed [16:0] I_MAX =  17'sd65535;

endpackage

// ===== rtl/irc_pow2neg.sv =====
// Three-stage 2^-t evaluator: quadratic fraction polynomial, then integer shift.
// Depends on irc_pkg.
module irc_pow2neg (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  irc_pkg::ulog_t         t_i,
  output logic [irc_pkg::QW-1:0] p_o
);
  import irc_pkg::*;

  logic [15:0]    f;
  logic [LW-17:0] n;
  logic [31:0]    ff_q, lf_q, lf2_q;
  logic [45:0]    sq_q;
  logic [4:0]     sh_q, sh2_q;
  logic [47:0]    tt;
  logic [QW-1:0]  pf;
  logic [QW-1:0]  p_q;

  assign f  = t_i[15:0];
  assign n  = t_i[LW-1:16];
  assign tt = {lf2_q, 16'b0} - {2'b0, sq_q};
  assign pf = Q_ONE - {1'b0, tt[47:32]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ff_q  <= 32'(f) * 32'(f);
      lf_q  <= 32'(P_LIN) * 32'(f);
      sh_q  <= (n > (LW-16)'(16)) ? SH_ZERO : 5'(n);
      sq_q  <= 46'(P_SQR) * 46'(ff_q);
      lf2_q <= lf_q;
      sh2_q <= sh_q;
      p_q   <= (sh2_q == SH_ZERO) ? '0 : (pf >> sh2_q);
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/irc_log1p.sv =====
// Two-stage log2(1+u) approximation for u in unsigned Q16 [0, 1].
// Depends on irc_pkg.
module irc_log1p (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [irc_pkg::QW-1:0] u_i,
  output logic [irc_pkg::QW-1:0] g_o
);
  import irc_pkg::*;

  logic [31:0]   mu_q;
  logic [QW-1:0] u_q;
  logic [32:0]   inner;
  logic [49:0]   prod;
  logic [QW-1:0] g_q;

  assign inner = L_LIN_SH - {1'b0, mu_q};
  assign prod  = 50'(u_q) * 50'(inner);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mu_q <= 32'(L_SQR) * 32'(u_i);
      u_q  <= u_i;
      g_q  <= prod[48:32];
    end
  end

  assign g_o = g_q;

endmodule

// ===== rtl/irc_lse.sv =====
// Log-sum-exp unit, log2(2^a + 2^b) = max + log2(1 + 2^-|a-b|), seven stages.
// Depends on irc_pkg, irc_pow2neg and irc_log1p.
module irc_lse (
  input  logic          clk_i,
  input  logic          en_i,
  input  irc_pkg::log_t a_i,
  input  irc_pkg::log_t b_i,
  output irc_pkg::log_t y_o
);
  import irc_pkg::*;

  logic signed [LW:0] diff;
  logic [LW:0]        adiff;
  log_t               m;
  log_t               m_q [6];
  ulog_t              t_q;
  logic [QW-1:0]      p;
  logic [QW-1:0]      g;
  log_t               y_q;

  assign diff  = {a_i[LW-1], a_i} - {b_i[LW-1], b_i};
  assign adiff = diff[LW] ? (LW+1)'(-diff) : (LW+1)'(diff);
  assign m     = (a_i > b_i) ? a_i : b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m;
      t_q    <= adiff[LW-1:0];
      for (int k = 1; k < 6; k++) begin
        m_q[k] <= m_q[k-1];
      end
      y_q <= m_q[5] + LW'(g);
    end
  end

  irc_pow2neg u_pow (
    .clk_i (clk_i),
    .en_i  (en_i),
    .t_i   (t_q),
    .p_o   (p)
  );

  irc_log1p u_log (
    .clk_i (clk_i),
    .en_i  (en_i),
    .u_i   (p),
    .g_o   (g)
  );

  assign y_o = y_q;

endmodule

// ===== rtl/inward_rectifier_current.sv =====
// Inward rectifier potassium current, one membrane voltage per clock unless the pipeline holds;
// a result turns valid once it passes from the result register into the output queue.
// A 25-stage pipeline (driving force, linear exponents, three parallel log-sum-exp units,
// a fourth for the gate, 2^-t, then the two current products and the result register)
// takes a new item every cycle while out_ready_i is high; a two-entry output queue keeps
// input flowing while a result waits. The whole pipeline holds when the queue is full, not
// drained and the last stage holds a result.
// Registers over APB: 0x0 reversal potential (17b signed), 0x4 conductance gain (18b Q16).
// Depends on irc_pkg, irc_lse, irc_pow2neg and assert_macros.svh.
`include "assert_macros.svh"

module inward_rectifier_current (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [irc_pkg::VW-1:0] membrane_voltage_i,
  input  logic                          at_time_zero_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [irc_pkg::QW-1:0]        gate_steady_state_o,
  output logic signed [16:0]            current_o
);
  import irc_pkg::*;

  localparam int NS = 25;
  localparam int DL = 23;
  localparam logic REG_EK   = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  typedef struct packed {
    logic [QW-1:0]      gate;
    logic signed [16:0] cur;
  } res_t;

  logic signed [VW-1:0] ek_q;
  logic [GW-1:0]        gain_q;
  logic                 cfg_wr;

  logic                 en;
  logic                 vld_q [1:NS];
  logic                 tz_q  [1:NS-1];
  logic signed [DW-1:0] d_q   [1:DL];

  logic signed [19:0]   sa, sb1, sb2, sc;
  logic signed [36:0]   pa_q, pb1_q, pb2_q, pc_q;
  log_t                 la_q, lb1_q, lb2_q, lc_q;
  log_t                 ya, yb, yc, x_q, z;
  logic [QW-1:0]        gate;
  logic [QW-1:0]        gate22_q, gate23_q;
  logic [34:0]          gg_q;
  logic signed [53:0]   p_q;
  logic signed [54:0]   rnd;
  logic signed [22:0]   cur_w;
  logic signed [16:0]   cur_sat;
  res_t                 res_q;

  res_t                 fifo_q [2];
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;
  logic                 push, pop;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ek_q   <= -17'sd22016;
      gain_q <= 18'd22938;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_EK:   ek_q   <= pwdata[VW-1:0];
        REG_GAIN: gain_q <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_EK:   prdata = 32'(ek_q);
      REG_GAIN: prdata = 32'(gain_q);
      default:  prdata = '0;
    endcase
  end

  // pipeline control: all moves together unless a result meets a full, undrained queue
  assign en         = !vld_q[NS] || (cnt_q != 2'd2) || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[1] <= in_valid_i;
      for (int k = 2; k <= NS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign sa  = 20'(d_q[2]) + C_ALPHA;
  assign sb1 = 20'(d_q[2]) + C_B1;
  assign sb2 = 20'(d_q[2]) + C_B2;
  assign sc  = 20'(d_q[2]) + C_DEN;

  assign rnd     = 55'(p_q) + (55'sd1 <<< 31);
  assign cur_w   = rnd[54:32];
  assign cur_sat = (cur_w < 23'(I_MIN)) ? I_MIN :
                   (cur_w > 23'(I_MAX)) ? I_MAX : cur_w[16:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[1]  <= DW'(membrane_voltage_i) - DW'(ek_q);
      tz_q[1] <= at_time_zero_i;
      for (int k = 2; k <= DL; k++) begin
        d_q[k] <= d_q[k-1];
      end
      for (int k = 2; k <= NS-1; k++) begin
        tz_q[k] <= tz_q[k-1];
      end
      // products; d_q[2] lines up with these stages via the delay line offset
      pa_q  <= 37'(sa)  * 37'(K_ALPHA);
      pb1_q <= 37'(sb1) * 37'(K_B1);
      pb2_q <= 37'(sb2) * 37'(K_B2);
      pc_q  <= 37'(sc)  * 37'(K_DEN);
      la_q  <= LW'(pa_q >>> 8);
      lb1_q <= LW'(pb1_q >>> 8) + LOG2_B1;
      lb2_q <= LW'(pb2_q >>> 8);
      lc_q  <= LW'(pc_q >>> 8);
      x_q   <= (yb - yc) + (ya - LOG2_ALPHA0);
      gg_q     <= 35'(gain_q) * 35'(gate);
      gate22_q <= gate;
      p_q      <= 54'($signed({1'b0, gg_q})) * 54'(d_q[DL]);
      gate23_q <= gate22_q;
      if (tz_q[NS-1]) begin
        res_q.gate <= '0;
        res_q.cur  <= '0;
      end else begin
        res_q.gate <= gate23_q;
        res_q.cur  <= cur_sat;
      end
    end
  end

  irc_lse u_lse_alpha (
    .clk_i (clk_i), .en_i (en), .a_i ('0), .b_i (la_q), .y_o (ya)
  );

  irc_lse u_lse_beta (
    .clk_i (clk_i), .en_i (en), .a_i (lb1_q), .b_i (lb2_q), .y_o (yb)
  );

  irc_lse u_lse_den (
    .clk_i (clk_i), .en_i (en), .a_i ('0), .b_i (lc_q), .y_o (yc)
  );

  irc_lse u_lse_gate (
    .clk_i (clk_i), .en_i (en), .a_i ('0), .b_i (x_q), .y_o (z)
  );

  // z is never negative: lse(0, x) >= 0
  irc_pow2neg u_gate (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (ulog_t'(z)),
    .p_o   (gate)
  );

  // output queue
  assign push = en && vld_q[NS];
  assign pop  = (cnt_q != 2'd0) && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign out_valid_o         = (cnt_q != 2'd0);
  assign gate_steady_state_o = fifo_q[rd_q].gate;
  assign current_o           = fifo_q[rd_q].cur;

  `IRC_ASSERT(a_cnt_bound, cnt_q <= 2'd2)
  `IRC_ASSERT_IMPL(a_no_overrun, push && (cnt_q == 2'd2), pop)
  `IRC_ASSERT_NEXT(a_stall_holds, !en, $stable(res_q) && vld_q[NS])

endmodule

// ===== tb/ik1_checker.sv =====
// Checker for inward_rectifier_current: tracks APB register writes, predicts each result
// from the accepted voltage items, and compares results in order. Needs only the DUT ports.
module ik1_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic signed [16:0] membrane_voltage_i,
  input  logic               at_time_zero_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [16:0]        gate_steady_state_o,
  input  logic signed [16:0] current_o,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam logic [2:0] ADDR_EK   = 3'd0;
  localparam logic [2:0] ADDR_GAIN = 3'd4;

  typedef struct packed {
    logic [16:0]        gate;
    logic signed [16:0] cur;
  } ik1_result_t;

  ik1_result_t    ik1_expected_q[$];
  longint         ek_mirror;
  longint         gain_mirror;

  // 2^-f, f in [0,1) Q16
  function automatic longint exp2_frac(longint f);
    return 65536 - ((longint'(44013) * f * 65536 - longint'(11245) * f * f) >>> 32);
  endfunction

  function automatic longint exp2_neg(longint t);
    longint n;
    n = t >>> 16;
    if (n > 16) return 0;
    return exp2_frac(t & 65535) >>> n;
  endfunction

  function automatic longint log2_1p(longint u);
    return (u * (longint'(87818) * 65536 - longint'(22282) * u)) >>> 32;
  endfunction

  function automatic longint log_add(longint a, longint b);
    longint m, t;
    m = (a > b) ? a : b;
    t = (a > b) ? a - b : b - a;
    return m + log2_1p(exp2_neg(t));
  endfunction

  function automatic longint exp_arg(longint d, longint c, longint k);
    return ((d + c) * k) >>> 8;
  endfunction

  function automatic ik1_result_t predict_ik1(longint v, logic tz);
    ik1_result_t r;
    longint d, la, lb, g, c;
    r = '0;
    if (!tz) begin
      d  = v - ek_mirror;
      la = 1872 - log_add(0, exp_arg(d, -15159, 22550));
      lb = log_add(-67207 + exp_arg(d, 1402, 7594), exp_arg(d, -152143, 5838))
           - log_add(0, exp_arg(d, 1217, -48626));
      g  = exp2_neg(log_add(0, lb - la));
      c  = (gain_mirror * g * d + (longint'(1) << 31)) >>> 32;
      if (c < -65536) c = -65536;
      if (c > 65535) c = 65535;
      r.gate = g[16:0];
      r.cur  = c[16:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors_o++;
  endtask

  assign pending_o = ik1_expected_q.size();

  initial begin
    errors_o  = 0;
    checked_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    ik1_result_t e;
    if (!rst_ni) begin
      ek_mirror   <= -22016;
      gain_mirror <= 22938;
      ik1_expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_EK) ek_mirror <= longint'(signed'(pwdata[16:0]));
        else if (paddr == ADDR_GAIN) gain_mirror <= longint'(pwdata[17:0]);
      end
      if (in_valid_i && in_ready_o)
        ik1_expected_q.push_back(predict_ik1(longint'(membrane_voltage_i), at_time_zero_i));
      if (out_valid_o && out_ready_i) begin
        if (ik1_expected_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = ik1_expected_q.pop_front();
          checked_o++;
          if (gate_steady_state_o !== e.gate)
            report_mismatch($sformatf("gate %0d, want %0d", gate_steady_state_o, e.gate));
          if (current_o !== e.cur)
            report_mismatch($sformatf("current %0d, want %0d", current_o, e.cur));
        end
      end
    end
  end

endmodule

// ===== tb/tb_inward_rectifier_current.sv =====
// Top of the inward_rectifier_current testbench: clock, reset, APB setup, voltage items
// and output stalls. Depends on the DUT, irc_pkg and ik1_checker.
module tb_inward_rectifier_current;

  localparam logic [2:0] ADDR_EK   = 3'd0;
  localparam logic [2:0] ADDR_GAIN = 3'd4;
  localparam int         CYCLE_LIMIT = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [16:0] membrane_voltage_i = '0;
  logic               at_time_zero_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [16:0]        gate_steady_state_o;
  logic signed [16:0] current_o;
  int                 errors, pending, checked;
  int                 cycles = 0;
  int                 items = 0;
  logic               steady = 1'b0;  // no idling on either side while set
  logic signed [16:0] ek_now = -17'sd22016;

  always #2 clk_i = ~clk_i;

  inward_rectifier_current DUT (.*);

  ik1_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_o, .membrane_voltage_i, .at_time_zero_i,
    .out_valid_o, .out_ready_i, .gate_steady_state_o, .current_o,
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 26);
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_voltage(logic signed [16:0] v, logic tz);
    in_valid_i <= 1'b1;
    membrane_voltage_i <= v;
    at_time_zero_i <= tz;
    do @(posedge clk_i); while (!in_ready_o);
    items++;
    // each following cycle idles with the same odds
    if (!steady) begin
      while ($urandom_range(99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_regs(logic signed [16:0] ek, logic [17:0] gain);
    reg_write(ADDR_EK, 32'(ek));
    reg_write(ADDR_GAIN, 32'(gain));
    ek_now = ek;
  endtask

  task automatic random_items(int n);
    logic signed [16:0] v;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 20) v = 17'($urandom);
      else if (kind < 55) v = 17'($signed($urandom_range(102400)) - 51200);
      else v = ek_now + 17'($signed($urandom_range(10000)) - 5000);
      send_voltage(v, $urandom_range(99) < 8);
    end
  endtask

  initial begin
    logic signed [16:0] corner_v[10];
    corner_v = '{-17'sd65536, 17'sd65535, -17'sd51200, 17'sd51200, 17'sd0,
                 -17'sd22016, -17'sd22015, -17'sd20000, -17'sd7000, 17'sd15000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: voltage extremes, near EK, time-zero
    foreach (corner_v[i]) send_voltage(corner_v[i], 1'b0);
    send_voltage(17'sd65535, 1'b1);
    send_voltage(-17'sd65536, 1'b1);
    send_voltage(17'sd1234, 1'b1);
    drain();

    // driving force at its widest: EK at extremes, gain at max
    set_regs(-17'sd65536, 18'h3FFFF);
    send_voltage(17'sd65535, 1'b0);
    send_voltage(-17'sd65536, 1'b0);
    send_voltage(17'sd0, 1'b0);
    drain();
    set_regs(17'sd65535, 18'h3FFFF);
    send_voltage(-17'sd65536, 1'b0);
    send_voltage(17'sd65535, 1'b0);
    send_voltage(17'sd0, 1'b0);
    drain();

    set_regs(-17'sd22016, 18'd22938);
    random_items(300);
    drain();
    steady = 1'b1;
    set_regs(-17'sd51200, 18'h3FFFF);
    random_items(250);
    drain();
    steady = 1'b0;
    set_regs(17'sd51200, 18'd0);
    random_items(200);
    drain();
    set_regs(17'($urandom), 18'($urandom));
    random_items(250);
    drain();
    set_regs(-17'sd65536, 18'd131072);
    random_items(230);
    drain();

    $display("sent %0d voltage items over 8 register settings, %0d results compared",
             items, checked);
    $display("covered EK and gain extremes, time-zero items and both-side stalls");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
